// File: rtl/pidw_pkg.sv
package pidw_pkg;

  localparam int GAIN_W = 16;
  localparam int LIM_W  = 16;
  localparam int ENC_W  = 15;
  localparam int POS_W  = 16;
  localparam int ERR_W  = POS_W + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int FRAC_W = 8;
  localparam int TERM_W = GAIN_W + DIFF_W - FRAC_W;
  localparam int ACC_W  = TERM_W + 2;
  localparam int DRV_W  = LIM_W + 1;
  localparam int CIDX_W = 4;

  typedef enum logic [CIDX_W-1:0] {
    CFG_KP          = 4'd0,
    CFG_KI          = 4'd1,
    CFG_KD          = 4'd2,
    CFG_KF          = 4'd3,
    CFG_MAX_OUTPUT  = 4'd4,
    CFG_INT_LIMIT   = 4'd5,
    CFG_ENCODER_MAX = 4'd6,
    CFG_WRAP_ENABLE = 4'd7
  } cfg_idx_t;

  localparam logic [LIM_W-1:0] MAX_OUTPUT_RST = 16'hFFFF;
  localparam logic [LIM_W-1:0] INT_LIMIT_RST  = 16'hFFFF;
  localparam logic [ENC_W-1:0] ENCODER_MAX_RST = 15'd8191;

endpackage

// File: rtl/pidw_term.sv
module pidw_term (
  input  logic signed [pidw_pkg::GAIN_W-1:0] gain,
  input  logic signed [pidw_pkg::DIFF_W-1:0] operand,
  output logic signed [pidw_pkg::TERM_W-1:0] term
);

  logic signed [pidw_pkg::GAIN_W+pidw_pkg::DIFF_W-1:0] product;

  // Dropping the fraction bits of a two's complement product rounds towards minus infinity.
  assign product = gain * operand;
  assign term    = product[pidw_pkg::GAIN_W+pidw_pkg::DIFF_W-1:pidw_pkg::FRAC_W];

endmodule

// File: rtl/positional_pid_angle_wrap.sv
// Channel  Direction  Beat contents                 Handshake
// in       input      cmd, target, measured         in_valid / in_ready
// out      output     drive                         out_valid / out_ready
// cfg      input      register index, write data    cfg_valid / cfg_ready (always ready)
//
// One beat is accepted per cycle while in_ready is high; each run beat yields one drive beat.
// The error, wrap and differences are formed as the beat is taken, the four gain products in
// the next stage, the integral clamp in the third and the output clamp in the output register.
// A clear beat passes through the first two stages and gives no result.
// Reset (synchronous, rst_n low) empties the pipeline, zeroes the stored state and restores
// the register defaults. Each stage holds while the one after it is full and stalled, so input
// beats are refused only when all four stages are occupied and out_ready is low.
module positional_pid_angle_wrap (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic signed [pidw_pkg::POS_W-1:0]    in_target,
  input  logic signed [pidw_pkg::POS_W-1:0]    in_measured,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pidw_pkg::DRV_W-1:0]    out_drive,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidw_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [pidw_pkg::LIM_W-1:0]           cfg_data
);

  localparam int ERR_W  = pidw_pkg::ERR_W;
  localparam int DIFF_W = pidw_pkg::DIFF_W;
  localparam int TERM_W = pidw_pkg::TERM_W;
  localparam int ACC_W  = pidw_pkg::ACC_W;
  localparam int POS_W  = pidw_pkg::POS_W;
  localparam int LIM_W  = pidw_pkg::LIM_W;
  localparam int ENC_W  = pidw_pkg::ENC_W;
  localparam int DRV_W  = pidw_pkg::DRV_W;

  logic signed [pidw_pkg::GAIN_W-1:0] kp_r, ki_r, kd_r, kf_r;
  logic [LIM_W-1:0]                   max_out_r, int_lim_r;
  logic [ENC_W-1:0]                   enc_max_r;
  logic                               wrap_en_r;

  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [POS_W-1:0]  prev_tgt_r;
  logic signed [ERR_W-1:0]  isum_r;

  logic                     v1_r, v2_r, v3_r, v4_r;
  logic                     rdy1, rdy2, rdy3, rdy4, take1;

  logic                     cmd1_r;
  logic signed [ERR_W-1:0]  err1_r;
  logic signed [DIFF_W-1:0] derr1_r;
  logic signed [ERR_W-1:0]  dtgt1_r;

  logic                     cmd2_r;
  logic signed [TERM_W-1:0] p2_r, i2_r, d2_r, f2_r;
  logic signed [TERM_W-1:0] p_term, i_term, d_term, f_term;

  logic signed [ACC_W-1:0]  psum3_r;
  logic signed [ERR_W-1:0]  int3_r;
  logic signed [DRV_W-1:0]  drive_r;

  logic signed [ERR_W-1:0]  err_raw, err_wrap, wrap_span, dtgt;
  logic [ERR_W-1:0]         err_mag;
  logic [LIM_W-1:0]         span_u;
  logic                     wrap_hit, err_pos;
  logic signed [DIFF_W-1:0] derr;

  logic signed [TERM_W-1:0] iacc, ilim_s;
  logic signed [ERR_W-1:0]  isum_nxt;
  logic signed [ACC_W-1:0]  psum_nxt, total, olim_s;
  logic signed [DRV_W-1:0]  drive_nxt;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r      <= '0;
      ki_r      <= '0;
      kd_r      <= '0;
      kf_r      <= '0;
      max_out_r <= pidw_pkg::MAX_OUTPUT_RST;
      int_lim_r <= pidw_pkg::INT_LIMIT_RST;
      enc_max_r <= pidw_pkg::ENCODER_MAX_RST;
      wrap_en_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (pidw_pkg::cfg_idx_t'(cfg_index))
        pidw_pkg::CFG_KP:          kp_r      <= $signed(cfg_data);
        pidw_pkg::CFG_KI:          ki_r      <= $signed(cfg_data);
        pidw_pkg::CFG_KD:          kd_r      <= $signed(cfg_data);
        pidw_pkg::CFG_KF:          kf_r      <= $signed(cfg_data);
        pidw_pkg::CFG_MAX_OUTPUT:  max_out_r <= cfg_data;
        pidw_pkg::CFG_INT_LIMIT:   int_lim_r <= cfg_data;
        pidw_pkg::CFG_ENCODER_MAX: enc_max_r <= cfg_data[ENC_W-1:0];
        pidw_pkg::CFG_WRAP_ENABLE: wrap_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign take1    = in_valid && rdy1;

  // Error with shortest-path wrap, and the differences against the stored state.
  always_comb begin
    err_raw   = $signed({in_target[POS_W-1], in_target}) -
                $signed({in_measured[POS_W-1], in_measured});
    err_mag   = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
    wrap_hit  = wrap_en_r && ({err_mag, 1'b0} > {3'b000, enc_max_r});
    span_u    = {1'b0, enc_max_r} + LIM_W'(1);
    wrap_span = $signed({1'b0, span_u});
    err_pos   = !err_raw[ERR_W-1] && (err_raw != '0);
    if (!wrap_hit) begin
      err_wrap = err_raw;
    end else if (err_pos) begin
      err_wrap = err_raw - wrap_span;
    end else begin
      err_wrap = err_raw + wrap_span;
    end
    derr = $signed({err_wrap[ERR_W-1], err_wrap}) -
           $signed({prev_err_r[ERR_W-1], prev_err_r});
    dtgt = $signed({in_target[POS_W-1], in_target}) -
           $signed({prev_tgt_r[POS_W-1], prev_tgt_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      prev_tgt_r <= '0;
    end else if (take1) begin
      if (in_cmd) begin
        prev_err_r <= '0;
      end else begin
        prev_err_r <= err_wrap;
        prev_tgt_r <= in_target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      cmd1_r  <= in_cmd;
      err1_r  <= err_wrap;
      derr1_r <= derr;
      dtgt1_r <= dtgt;
    end
  end

  // Gain products.
  pidw_term u_term_p (
    .gain    (kp_r),
    .operand ($signed({err1_r[ERR_W-1], err1_r})),
    .term    (p_term)
  );

  pidw_term u_term_i (
    .gain    (ki_r),
    .operand ($signed({err1_r[ERR_W-1], err1_r})),
    .term    (i_term)
  );

  pidw_term u_term_d (
    .gain    (kd_r),
    .operand (derr1_r),
    .term    (d_term)
  );

  pidw_term u_term_f (
    .gain    (kf_r),
    .operand ($signed({dtgt1_r[ERR_W-1], dtgt1_r})),
    .term    (f_term)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      cmd2_r <= cmd1_r;
      p2_r   <= p_term;
      i2_r   <= i_term;
      d2_r   <= d_term;
      f2_r   <= f_term;
    end
  end

  // Integral accumulation with clamp, and the sum of the other three terms.
  always_comb begin
    ilim_s = $signed({{(TERM_W-LIM_W){1'b0}}, int_lim_r});
    iacc   = $signed({{(TERM_W-ERR_W){isum_r[ERR_W-1]}}, isum_r}) + i2_r;
    if (iacc > ilim_s) begin
      isum_nxt = $signed({1'b0, int_lim_r});
    end else if (iacc < -ilim_s) begin
      isum_nxt = ERR_W'(-ilim_s);
    end else begin
      isum_nxt = iacc[ERR_W-1:0];
    end
    psum_nxt = $signed({{(ACC_W-TERM_W){p2_r[TERM_W-1]}}, p2_r}) +
               $signed({{(ACC_W-TERM_W){d2_r[TERM_W-1]}}, d2_r}) +
               $signed({{(ACC_W-TERM_W){f2_r[TERM_W-1]}}, f2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isum_r <= '0;
      v3_r   <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r && !cmd2_r;
      if (v2_r) begin
        isum_r <= cmd2_r ? '0 : isum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      psum3_r <= psum_nxt;
      int3_r  <= isum_nxt;
    end
  end

  // Output saturation.
  always_comb begin
    olim_s = $signed({{(ACC_W-LIM_W){1'b0}}, max_out_r});
    total  = psum3_r + $signed({{(ACC_W-ERR_W){int3_r[ERR_W-1]}}, int3_r});
    if (total > olim_s) begin
      drive_nxt = $signed({1'b0, max_out_r});
    end else if (total < -olim_s) begin
      drive_nxt = DRV_W'(-olim_s);
    end else begin
      drive_nxt = total[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_drive = drive_r;

  // Input beats are refused only when every stage is occupied.
  a_refuse_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && v4_r))
    else $error("input refused while the pipeline has a free stage");

  // A clear beat zeroes the stored error as it is taken.
  a_clear_error: assert property (@(posedge clk) disable iff (!rst_n)
    (take1 && in_cmd) |=> (prev_err_r == '0))
    else $error("stored error not zeroed by a clear beat");

  // A clear beat zeroes the integral as it leaves the product stage.
  a_clear_integral: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && cmd2_r && rdy3) |=> (isum_r == '0 && !v3_r))
    else $error("clear beat did not zero the integral or reached the output");

  // A result appears only behind an item in the integral stage.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v3_r))
    else $error("result appeared without an item behind it");

endmodule
